// ===== hw/rtl/arx_pkg.sv =====
// Shared types, constants and helpers for the ARX / IIR filter step unit.
package arx_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int ACC_W      = 40;
	localparam int DELAY_W    = 4;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int FRAC_SHIFT = 14;

	localparam int NUM_B_TAPS_DEF = 3;
	localparam int NUM_A_TAPS_DEF = 3;
	localparam int MAX_DELAY_DEF  = 8;

	// register map: delay, then b taps, then a taps
	localparam int CFG_INPUT_DELAY = 0;
	localparam int CFG_B_BASE      = 1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	typedef struct packed {
		sample_t sample_out;
		logic    saturated;
	} result_t;

	localparam coef_t   B0_RESET   = 16'sd16384;
	localparam sample_t SAMPLE_MAX = 16'sh7fff;
	localparam sample_t SAMPLE_MIN = 16'sh8000;
	localparam acc_t    ROUND_HALF = acc_t'(1) <<< (FRAC_SHIFT - 1);

	// Round half up, drop FRAC_SHIFT fraction bits, clip to Q1.15.
	function automatic result_t round_sat(input acc_t acc);
		acc_t    t;
		logic    hi_ones;
		logic    hi_zeros;
		result_t r;
		t        = acc + ROUND_HALF;
		hi_ones  = &t[ACC_W-1:FRAC_SHIFT+SAMPLE_W-1];
		hi_zeros = ~|t[ACC_W-1:FRAC_SHIFT+SAMPLE_W-1];
		r.saturated = !(hi_ones || hi_zeros);
		if (r.saturated) begin
			r.sample_out = t[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
		end else begin
			r.sample_out = t[FRAC_SHIFT+SAMPLE_W-1:FRAC_SHIFT];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/arx_if.sv =====
// Channel interfaces: input samples, results and configuration writes.
interface arx_sample_if import arx_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface arx_result_if import arx_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_out;
	logic    saturated;

	modport source (output valid, output sample_out, output saturated, input ready);
	modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

interface arx_cfg_if import arx_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/arx_delay_cell.sv =====
// One history cell: holds a sample and passes it to the next cell on shift.
module arx_delay_cell import arx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    shift_en,
	input  sample_t d,
	output sample_t q
);

	sample_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (shift_en) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

// ===== hw/rtl/arx_mac_cell.sv =====
// One tap of the accumulate chain: adds or subtracts coef * operand.
module arx_mac_cell import arx_pkg::*; #(
	parameter bit SUBTRACT = 1'b0
) (
	input  coef_t   coef,
	input  sample_t operand,
	input  acc_t    acc_in,
	output acc_t    acc_out
);

	logic signed [PROD_W-1:0] prod;
	acc_t                     prod_ext;

	assign prod     = coef * operand;
	assign prod_ext = acc_t'(prod);
	assign acc_out  = SUBTRACT ? (acc_in - prod_ext) : (acc_in + prod_ext);

endmodule

// ===== hw/rtl/arx_iir_filter_step_unit.sv =====
// Top level of the ARX / IIR direct-form-1 filter step unit.
// The unit takes one Q1.15 sample per transaction and returns one rounded,
// saturated Q1.15 output per sample in the cycle after the sample is
// accepted. It takes a new sample in every cycle as long as the result side
// is ready: one sample per clock sustained. The clock is bounded by the
// combinational accumulate chain through NUM_B_TAPS + NUM_A_TAPS multiply-add
// cells and rounding, closing feedback via the first output history cell.
// Inputs live in a row of MAX_DELAY + NUM_B_TAPS - 1 delay cells (the newest
// sample comes straight from the port); outputs in a row of NUM_A_TAPS cells,
// both zero after reset. input_delay picks the tap offset of the b cells and
// is clipped to MAX_DELAY. Config writes are always taken and should be made
// while no transaction is in flight; writes to unknown indexes are dropped.
module arx_iir_filter_step_unit import arx_pkg::*; #(
	parameter int NUM_B_TAPS = NUM_B_TAPS_DEF,
	parameter int NUM_A_TAPS = NUM_A_TAPS_DEF,
	parameter int MAX_DELAY  = MAX_DELAY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	arx_sample_if.sink     samp,
	arx_result_if.source   res,
	arx_cfg_if.sink        cfg
);

	localparam int IN_DEPTH = MAX_DELAY + NUM_B_TAPS;
	localparam int SEL_W    = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
	localparam int A_BASE   = CFG_B_BASE + NUM_B_TAPS;

	// configuration registers
	logic [DELAY_W-1:0] input_delay_q;
	coef_t              b_coef_q [NUM_B_TAPS];
	coef_t              a_coef_q [NUM_A_TAPS];

	logic               accept;
	logic [SEL_W-1:0]   delay_sel;
	sample_t            x_tap [IN_DEPTH];
	sample_t            y_hist [NUM_A_TAPS];
	sample_t            b_operand [NUM_B_TAPS];
	acc_t               acc_b [NUM_B_TAPS+1];
	acc_t               acc_a [NUM_A_TAPS+1];
	result_t            y_new;

	logic               res_valid_q;
	result_t            res_q;

	assign cfg.ready = 1'b1;

	// config write port, indexes decoded against the register map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_delay_q <= '0;
			for (int j = 0; j < NUM_B_TAPS; j++) begin
				b_coef_q[j] <= (j == 0) ? B0_RESET : '0;
			end
			for (int i = 0; i < NUM_A_TAPS; i++) begin
				a_coef_q[i] <= '0;
			end
		end else if (cfg.valid) begin
			if (cfg.index == CFG_IDX_W'(CFG_INPUT_DELAY)) begin
				input_delay_q <= cfg.data[DELAY_W-1:0];
			end
			for (int j = 0; j < NUM_B_TAPS; j++) begin
				if (cfg.index == CFG_IDX_W'(CFG_B_BASE + j)) begin
					b_coef_q[j] <= coef_t'(cfg.data);
				end
			end
			for (int i = 0; i < NUM_A_TAPS; i++) begin
				if (cfg.index == CFG_IDX_W'(A_BASE + i)) begin
					a_coef_q[i] <= coef_t'(cfg.data);
				end
			end
		end
	end

	// handshake: output register holds the result; while it is full, samp.ready follows res.ready
	assign samp.ready = !res_valid_q || res.ready;
	assign accept     = samp.valid && samp.ready;

	// dead time, clipped to MAX_DELAY so every b tap stays inside the input row
	assign delay_sel = (int'(input_delay_q) > MAX_DELAY) ? SEL_W'(MAX_DELAY)
	                                                     : SEL_W'(input_delay_q);

	// input row: tap 0 is the sample being accepted
	assign x_tap[0] = samp.sample_in;

	for (genvar g = 1; g < IN_DEPTH; g++) begin : g_x_row
		arx_delay_cell u_x_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (accept),
			.d        (x_tap[g-1]),
			.q        (x_tap[g])
		);
	end

	// b cells: each picks its tap at the dead-time offset
	assign acc_b[0] = '0;

	for (genvar g = 0; g < NUM_B_TAPS; g++) begin : g_b_chain
		assign b_operand[g] = x_tap[delay_sel + SEL_W'(g)];

		arx_mac_cell #(
			.SUBTRACT (1'b0)
		) u_b_cell (
			.coef    (b_coef_q[g]),
			.operand (b_operand[g]),
			.acc_in  (acc_b[g]),
			.acc_out (acc_b[g+1])
		);
	end

	// a cells: feedback from past outputs
	assign acc_a[0] = acc_b[NUM_B_TAPS];

	for (genvar g = 0; g < NUM_A_TAPS; g++) begin : g_a_chain
		arx_mac_cell #(
			.SUBTRACT (1'b1)
		) u_a_cell (
			.coef    (a_coef_q[g]),
			.operand (y_hist[g]),
			.acc_in  (acc_a[g]),
			.acc_out (acc_a[g+1])
		);
	end

	assign y_new = round_sat(acc_a[NUM_A_TAPS]);

	// output row keeps the clipped value, newest in cell 0
	for (genvar g = 0; g < NUM_A_TAPS; g++) begin : g_y_row
		arx_delay_cell u_y_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (accept),
			.d        ((g == 0) ? y_new.sample_out : y_hist[(g > 0) ? g - 1 : 0]),
			.q        (y_hist[g])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= y_new;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.sample_out = res_q.sample_out;
	assign res.saturated  = res_q.saturated;

	// an accepted sample always shows up as a result in the next cycle
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res.valid)
		else $error("accepted sample did not produce a result");

	// the value fed back equals the result just produced
	a_feedback_matches: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (y_hist[0] == res_q.sample_out))
		else $error("output history out of step with result");

	// a clip flag only comes with a full-scale value
	a_sat_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.saturated) |->
			(res.sample_out == SAMPLE_MAX || res.sample_out == SAMPLE_MIN))
		else $error("saturated result not at full scale");

	// filter state moves only with a transaction
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ($stable(y_hist[0]) && $stable(x_tap[IN_DEPTH-1])))
		else $error("filter history changed without a transaction");

endmodule
